@@ design/u2t_pkg.sv @@
// Shared types, constants and lookup functions for the UTF-8 to tracker charset decoder.
package u2t_pkg;

    // Character counter width and compare width against the 16-bit capacity register
    localparam int COUNT_BITS = 16;
    localparam int MAX_BITS   = 16;
    localparam int CMP_BITS   = (COUNT_BITS > MAX_BITS) ? COUNT_BITS : MAX_BITS;

    localparam int SEQ_COUNT  = 26;

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7e;
    localparam logic [7:0] NUL_BYTE = 8'h00;
    localparam logic [15:0] MAX_CHARS_RESET = 16'd255;

    // One result word handed from the front end to the output stage
    typedef struct packed {
        logic [7:0] symbol;
        logic       symbol_valid;
        logic       done_res;
        logic       illegal;
    } u2t_res_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } u2t_match_t;

    // Multi-byte sequences, first byte highest, and their one-byte codes
    localparam logic [2:0] SEQ_LEN [SEQ_COUNT] = '{
        3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd2,
        3'd3, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
        3'd3, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd2
    };

    localparam logic [7:0] SEQ_CODE [SEQ_COUNT] = '{
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
        8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c,
        8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h14, 8'h19, 8'h1b, 8'h1c, 8'h1d, 8'h1e,
        8'h1f, 8'hff
    };

    localparam logic [23:0] SEQ_BYTES [SEQ_COUNT] = '{
        24'h00c3b7, 24'h00c397, 24'he28693, 24'h00c3a4, 24'he28691, 24'h00c3a5,
        24'he281b0, 24'h00c2b9, 24'h00c2b2, 24'h00c2b3, 24'he281b4, 24'he281b5,
        24'he281b6, 24'h00c384, 24'h00c385, 24'he281b7, 24'he281b8, 24'he281b9,
        24'h00c3b6, 24'h00c396, 24'h00c2bd, 24'he2ac86, 24'he2ac87, 24'he2ac85,
        24'he29ea1, 24'h00c2a9
    };

    // Character length from the lead byte
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        case (b) inside
            [8'h00:8'hbf]: len = 3'd1;
            [8'hc0:8'hdf]: len = 3'd2;
            [8'he0:8'hef]: len = 3'd3;
            [8'hf0:8'hf7]: len = 3'd4;
            [8'hf8:8'hfb]: len = 3'd5;
            [8'hfc:8'hfd]: len = 3'd6;
            default:       len = 3'd1;
        endcase
        return len;
    endfunction

    // Parallel match of a finished character against the sequence table
    function automatic u2t_match_t match_char(input logic [2:0] len, input logic [23:0] seq);
        u2t_match_t m;
        m = '0;
        for (int k = SEQ_COUNT - 1; k >= 0; k--)
        begin
            if (SEQ_LEN[k] == len && SEQ_BYTES[k] == seq)
            begin
                m.hit  = 1'b1;
                m.code = SEQ_CODE[k];
            end
        end
        return m;
    endfunction

endpackage

@@ design/u2t_front.sv @@
// Front end: takes source bytes, assembles characters, matches them and emits result words.
module u2t_front import u2t_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    input  logic             in_valid,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             in_ready,
    output logic             push,
    output u2t_res_t         push_res
);

    logic [2:0]            rem_reg,     rem_next;
    logic [2:0]            len_reg,     len_next;
    logic [23:0]           bytes_reg,   bytes_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;
    logic                  illegal_reg, illegal_next;
    logic                  stopped_reg, stopped_next;
    logic [15:0]           max_reg;

    logic                  accept;
    logic                  emit;
    logic [7:0]            sym;
    logic [2:0]            lead_len;
    u2t_match_t            m;
    logic                  at_limit;

    assign accept   = in_valid && in_ready;
    assign lead_len = lead_length(in_byte);
    assign at_limit = (CMP_BITS'(count_reg) >= CMP_BITS'(max_reg)) || (count_reg == '1);
    assign m        = match_char(len_reg, {bytes_reg[15:0], in_byte});

    // Character assembly and classification
    always_comb
    begin
        rem_next     = rem_reg;
        len_next     = len_reg;
        bytes_next   = bytes_reg;
        count_next   = count_reg;
        illegal_next = illegal_reg;
        stopped_next = stopped_reg;
        emit         = 1'b0;
        sym          = 8'h00;

        if (!stopped_reg)
        begin
            if (rem_reg != 3'd0)
            begin
                bytes_next = {bytes_reg[15:0], in_byte};
                rem_next   = rem_reg - 3'd1;
                if (rem_reg == 3'd1)
                begin
                    if (m.hit)
                    begin
                        emit = 1'b1;
                        sym  = m.code;
                    end
                    else
                    begin
                        illegal_next = 1'b1;
                    end
                end
            end
            else if (in_byte == NUL_BYTE || at_limit)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + COUNT_BITS'(1);
                if (lead_len == 3'd1)
                begin
                    if (in_byte >= PRINT_LO && in_byte <= PRINT_HI)
                    begin
                        emit = 1'b1;
                        sym  = in_byte;
                    end
                    else
                    begin
                        illegal_next = 1'b1;
                    end
                end
                else
                begin
                    len_next   = lead_len;
                    bytes_next = {16'h0000, in_byte};
                    rem_next   = lead_len - 3'd1;
                end
            end
        end

        // cut-off character at end of string
        if (in_last && rem_next != 3'd0)
        begin
            illegal_next = 1'b1;
        end
    end

    assign push                  = accept && (emit || in_last);
    assign push_res.symbol       = sym;
    assign push_res.symbol_valid = emit;
    assign push_res.done_res     = in_last;
    assign push_res.illegal      = illegal_next;

    // State registers; end of string returns everything but the capacity to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            len_reg     <= '0;
            bytes_reg   <= '0;
            count_reg   <= '0;
            illegal_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                rem_reg     <= '0;
                len_reg     <= '0;
                bytes_reg   <= '0;
                count_reg   <= '0;
                illegal_reg <= 1'b0;
                stopped_reg <= 1'b0;
            end
            else
            begin
                rem_reg     <= rem_next;
                len_reg     <= len_next;
                bytes_reg   <= bytes_next;
                count_reg   <= count_next;
                illegal_reg <= illegal_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_CHARS_RESET;
        end
        else if (cfg_we)
        begin
            max_reg <= cfg_wdata;
        end
    end

endmodule

@@ design/u2t_queue.sv @@
// Two-entry queue of result words between the front end and the output stage.
module u2t_queue import u2t_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  u2t_res_t   push_res,
    input  logic       pop,
    output logic       full,
    output logic       not_empty,
    output u2t_res_t   head,
    output logic [1:0] level
);

    u2t_res_t   mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] level_reg, level_next;

    assign full      = (level_reg == 2'd2);
    assign not_empty = (level_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            level_reg <= level_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

@@ design/u2t_back.sv @@
// Output stage: registers the head result word and drives the master stream.
module u2t_back import u2t_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  u2t_res_t   q_head,
    output logic       q_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic [1:0] m_axis_tuser,
    output logic       m_axis_tlast
);

    logic     valid_reg;
    u2t_res_t res_reg;
    logic     load;

    // Load a new word when the register is empty or being taken this cycle
    assign load  = q_not_empty && (!valid_reg || m_axis_tready);
    assign q_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= q_head;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.symbol;
    assign m_axis_tuser  = {res_reg.illegal, res_reg.symbol_valid};
    assign m_axis_tlast  = res_reg.done_res;

endmodule

@@ design/utf8_to_tracker_charset_decoder.sv @@
// Top level of the UTF-8 to tracker charset decoder.
//
//  channel   | dir | handshake                     | word
//  ----------+-----+-------------------------------+-----------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata = in_byte, tlast = last
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata = symbol, tlast = done_res,
//            |     |                               | tuser = symbol_valid, illegal
//  cfg       | in  | cfg_we                        | cfg_wdata = max_chars
//
// One source byte is taken per cycle while the queue is not full; assembly and the 26-entry
// table match finish in the cycle the byte is taken. A result word passes from the front end
// through the two-entry queue and the output register to m_axis.
// Reset clears all string state and sets max_chars to 255.
// s_axis stalls only when the queue is full, which takes a stall on m_axis.
module utf8_to_tracker_charset_decoder import u2t_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,       // max_chars
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] symbol
    output logic [1:0]  m_axis_tuser,    // [0] symbol_valid, [1] illegal
    output logic        m_axis_tlast
);

    logic       push;
    u2t_res_t   push_res;
    logic       q_full;
    logic       q_not_empty;
    u2t_res_t   q_head;
    logic       q_pop;
    logic [1:0] q_level;

    assign s_axis_tready = !q_full;

    u2t_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .push      (push),
        .push_res  (push_res)
    );

    u2t_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head),
        .level     (q_level)
    );

    u2t_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A word without a symbol carries a zero symbol
    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
        else $error("symbol nonzero without symbol_valid");

    // Only the end of string produces a word without a symbol
    a_word_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
        else $error("result word with neither symbol nor done");

    // With the output side draining, the queue never fills
    a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
        $past(m_axis_tready) && $past(q_level != 2'd2) |-> q_level != 2'd2)
        else $error("queue filled while output was ready");

endmodule

@@ tb/utf8_to_tracker_charset_decoder_tb.sv @@
// Self-checking testbench for the UTF-8 to tracker charset decoder, with its own symbol predictor.
`timescale 1ns / 1ps

package u2t_tb_pkg;

    localparam int TRACKER_SEQS = 26;

    // Known multi-byte characters: {length, bytes with the first byte highest}
    localparam logic [26:0] TRACKER_SEQ [TRACKER_SEQS] = '{
        {3'd2, 24'h00c3b7}, {3'd2, 24'h00c397}, {3'd3, 24'he28693}, {3'd2, 24'h00c3a4},
        {3'd3, 24'he28691}, {3'd2, 24'h00c3a5}, {3'd3, 24'he281b0}, {3'd2, 24'h00c2b9},
        {3'd2, 24'h00c2b2}, {3'd2, 24'h00c2b3}, {3'd3, 24'he281b4}, {3'd3, 24'he281b5},
        {3'd3, 24'he281b6}, {3'd2, 24'h00c384}, {3'd2, 24'h00c385}, {3'd3, 24'he281b7},
        {3'd3, 24'he281b8}, {3'd3, 24'he281b9}, {3'd2, 24'h00c3b6}, {3'd2, 24'h00c396},
        {3'd2, 24'h00c2bd}, {3'd3, 24'he2ac86}, {3'd3, 24'he2ac87}, {3'd3, 24'he2ac85},
        {3'd3, 24'he29ea1}, {3'd2, 24'h00c2a9}
    };

    localparam logic [7:0] TRACKER_CODE [TRACKER_SEQS] = '{
        8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
        8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h14, 8'h19, 8'h1b, 8'h1c, 8'h1d, 8'h1e, 8'h1f, 8'hff
    };

    // One expected result word
    typedef struct {
        logic [7:0] symbol;
        logic       symbol_valid;
        logic       done_res;
        logic       illegal;
    } tracker_word_t;

    class charset_scoreboard;
        logic [15:0]   max_chars;
        logic [2:0]    bytes_left;
        logic [2:0]    char_len;
        logic [23:0]   char_bytes;
        logic [15:0]   char_count;
        logic          illegal_seen;
        logic          stopped;
        tracker_word_t expected_symbols[$];
        int            errors;

        function new();
            max_chars = 16'd255;
            errors    = 0;
            clear_string();
        endfunction

        function void clear_string();
            bytes_left   = '0;
            char_len     = '0;
            char_bytes   = '0;
            char_count   = '0;
            illegal_seen = 1'b0;
            stopped      = 1'b0;
        endfunction

        function logic [2:0] lead_len(logic [7:0] b);
            if (b < 8'hc0) return 3'd1;
            if (b < 8'he0) return 3'd2;
            if (b < 8'hf0) return 3'd3;
            if (b < 8'hf8) return 3'd4;
            if (b < 8'hfc) return 3'd5;
            if (b < 8'hfe) return 3'd6;
            return 3'd1;
        endfunction

        // Advance the string state by one accepted source byte
        function void take_source_byte(logic [7:0] b, logic is_last);
            tracker_word_t w;
            logic          emit;
            logic [7:0]    sym;
            logic [2:0]    len;
            emit = 1'b0;
            sym  = 8'h00;
            if (!stopped)
            begin
                if (bytes_left != 0)
                begin
                    // continuation bytes are taken unchecked
                    char_bytes = {char_bytes[15:0], b};
                    bytes_left = bytes_left - 3'd1;
                    if (bytes_left == 0)
                    begin
                        for (int k = 0; k < TRACKER_SEQS; k++)
                        begin
                            if (TRACKER_SEQ[k] == {char_len, char_bytes})
                            begin
                                emit = 1'b1;
                                sym  = TRACKER_CODE[k];
                            end
                        end
                        if (!emit)
                            illegal_seen = 1'b1;
                    end
                end
                else if (b == 8'h00 || char_count >= max_chars || char_count == 16'hffff)
                begin
                    stopped = 1'b1;
                end
                else
                begin
                    len        = lead_len(b);
                    char_count = char_count + 16'd1;
                    if (len == 3'd1)
                    begin
                        if (b >= 8'h20 && b <= 8'h7e)
                        begin
                            emit = 1'b1;
                            sym  = b;
                        end
                        else
                            illegal_seen = 1'b1;
                    end
                    else
                    begin
                        char_len   = len;
                        char_bytes = {16'h0000, b};
                        bytes_left = len - 3'd1;
                    end
                end
            end

            // a character cut off by the end of the string is illegal
            if (is_last && bytes_left != 0)
                illegal_seen = 1'b1;

            if (emit || is_last)
            begin
                w.symbol       = emit ? sym : 8'h00;
                w.symbol_valid = emit;
                w.done_res     = is_last;
                w.illegal      = illegal_seen;
                expected_symbols.push_back(w);
            end
            if (is_last)
                clear_string();
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result word with the oldest expectation
        function void check_symbol_word(logic [7:0] data, logic [1:0] user, logic tlast);
            tracker_word_t w;
            if (expected_symbols.size() == 0)
            begin
                $display("%0t: result word with none expected, expected none actual %h/%b/%b",
                         $time, data, user, tlast);
                errors++;
                return;
            end
            w = expected_symbols.pop_front();
            compare_field("symbol", w.symbol, data);
            compare_field("symbol_valid", {7'd0, w.symbol_valid}, {7'd0, user[0]});
            compare_field("illegal", {7'd0, w.illegal}, {7'd0, user[1]});
            compare_field("done", {7'd0, w.done_res}, {7'd0, tlast});
        endfunction
    endclass

endpackage

module utf8_to_tracker_charset_decoder_tb;
    import u2t_tb_pkg::*;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [15:0] cfg_wdata     = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;    // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;            // [7:0] symbol
    logic [1:0]  m_axis_tuser;            // [0] symbol_valid, [1] illegal
    logic        m_axis_tlast;

    charset_scoreboard sb;
    logic [7:0]        text_q[$];
    int                src_idle_pct = 0;
    int                snk_stall_pct = 0;
    int                sent_count = 0;

    utf8_to_tracker_charset_decoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Handshake monitor: inputs feed the predictor, outputs get checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_source_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_symbol_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // Present one word, with random idle cycles ahead of it, and wait until taken
    task automatic send_word(logic [7:0] b, logic is_last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_word(text_q[i], i == text_q.size() - 1);
    endtask

    // Stop input, wait for every expected word, then let the pipeline settle
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_symbols.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_chars(logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.max_chars = value;
    endtask

    // Append a known character, or one with its final byte replaced by a random continuation byte
    function automatic void push_table_char(int k, bit near_miss);
        logic [26:0] e;
        e = TRACKER_SEQ[k];
        if (e[26:24] == 3'd3)
            text_q.push_back(e[23:16]);
        text_q.push_back(e[15:8]);
        text_q.push_back(near_miss ? 8'($urandom_range(8'h80, 8'hbf)) : e[7:0]);
    endfunction

    // Random string: mostly well-formed characters, some noise and cut-off tails
    function automatic void build_random_text();
        int nchars;
        int r;
        int nlen;
        text_q.delete();
        nchars = ($urandom_range(99) < 3) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int c = 0; c < nchars; c++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                text_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
            else if (r < 60)
                push_table_char($urandom_range(TRACKER_SEQS - 1), 1'b0);
            else if (r < 67)
                push_table_char($urandom_range(TRACKER_SEQS - 1), 1'b1);
            else if (r < 80)
            begin
                // random 2..6 byte character, continuations mostly well-formed
                text_q.push_back(8'($urandom_range(8'hc0, 8'hfd)));
                nlen = sb.lead_len(text_q[$]);
                for (int j = 1; j < nlen; j++)
                    text_q.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                             : 8'($urandom_range(8'h80, 8'hbf)));
            end
            else if (r < 90)
            begin
                // stray lead: control, DEL, lone continuation, 0xFE/0xFF
                case ($urandom_range(3))
                    0:       text_q.push_back(8'($urandom_range(8'h01, 8'h1f)));
                    1:       text_q.push_back(8'h7f);
                    2:       text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
                    default: text_q.push_back(8'($urandom_range(8'hfe, 8'hff)));
                endcase
            end
            else if (r < 93)
                text_q.push_back(8'h00);
            else
                text_q.push_back(8'($urandom_range(255)));
        end
        // unfinished character at the end
        if ($urandom_range(99) < 15)
        begin
            text_q.push_back(8'($urandom_range(8'hc0, 8'hfd)));
            if ($urandom_range(1) == 1)
                text_q.push_back(8'($urandom_range(8'h80, 8'hbf)));
        end
    endfunction

    // Main sequence
    initial
    begin
        int          phase_start;
        logic [15:0] setting;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings at the reset capacity
        text_q = '{8'h20, 8'h41, 8'h7e};
        send_text();
        text_q = '{8'hc3, 8'hb7, 8'he2, 8'h86, 8'h93, 8'hc2, 8'ha9};
        send_text();
        text_q = '{8'h7f, 8'h80, 8'hff, 8'h01};
        send_text();
        text_q = '{8'hf0, 8'h9f, 8'h98, 8'h80};
        send_text();
        text_q = '{8'hc3, 8'h00};
        send_text();
        text_q = '{8'h41, 8'h00, 8'h42};
        send_text();
        text_q = '{8'he2, 8'h86};
        send_text();

        // zero capacity: first lead stops the string
        finish_phase();
        write_max_chars(16'd0);
        text_q = '{8'h41, 8'h42};
        send_text();

        // random phases over idle modes and capacities
        for (int ph = 0; ph < 8; ph++)
        begin
            finish_phase();
            case (ph % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 50; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 50; end
                default: begin src_idle_pct = 11; snk_stall_pct = 11; end
            endcase
            case (ph)
                0:       setting = 16'd255;
                1:       setting = 16'd3;
                2:       setting = 16'd65535;
                3:       setting = 16'd1;
                4:       setting = 16'($urandom_range(2, 16));
                5:       setting = 16'd7;
                6:       setting = 16'($urandom_range(1, 40));
                default: setting = 16'd255;
            endcase
            write_max_chars(setting);
            phase_start = sent_count;
            while (sent_count - phase_start < 225)
            begin
                build_random_text();
                send_text();
            end
        end

        finish_phase();
        if (sb.errors == 0 && sb.expected_symbols.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
